>>> rtl/core/gasp_pkg.sv
`timescale 1ns / 1ps
// gasp_pkg: shared types, constants and codes of the glyph atlas shelf packer
// no dependencies
package gasp_pkg;

	localparam int ATLAS_WIDTH     = 512;
	localparam int ATLAS_HEIGHT    = 512;
	localparam int MAX_GLYPH_WIDTH = 32;
	localparam int COORD_W         = 10;
	localparam int WORD_BITS       = 64;
	localparam int OFF_W           = $clog2(WORD_BITS);
	localparam int ROW_WORDS       = ATLAS_WIDTH / WORD_BITS;
	localparam int ATLAS_WORDS     = ROW_WORDS * ATLAS_HEIGHT;
	localparam int WORD_AW         = $clog2(ATLAS_WORDS);
	localparam int ROW_AW          = $clog2(ATLAS_HEIGHT);
	localparam int COL_AW          = $clog2(ATLAS_WIDTH);
	localparam int PAT_W           = MAX_GLYPH_WIDTH;
	localparam int FIFO_DEPTH      = 4;
	localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		KIND_PLACE = 2'd0,
		KIND_ROW   = 2'd1,
		KIND_READ  = 2'd2,
		KIND_BAD   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_RESULT = 2'd0,
		OP_WRITE  = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_RDA,
		BK_RDB,
		BK_WRA,
		BK_WRB,
		BK_RDR,
		BK_OUT
	} bk_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  glyph_width;
		logic [9:0]  glyph_height;
		logic [63:0] row_text;
		logic [3:0]  row_length;
		logic [14:0] read_address;
	} in_item_t;

	typedef struct packed {
		logic [9:0] place_x;
		logic [9:0] place_y;
		logic       placed;
		logic       rejected;
		logic [7:0] read_data;
		logic [9:0] used_height;
	} out_item_t;

	typedef struct packed {
		op_t                op;
		out_item_t          res;
		logic [WORD_AW-1:0] word_addr;
		logic [OFF_W-1:0]   bit_off;
		logic [PAT_W-1:0]   pattern;
		logic [PAT_W-1:0]   mask;
		logic [2:0]         byte_sel;
	} cmd_t;

endpackage

>>> rtl/core/glyph_atlas_shelf_packer.sv
`timescale 1ns / 1ps
// glyph_atlas_shelf_packer: top level joining front, command queue and back
// uses gasp_pkg, gasp_front, gasp_fifo, gasp_back
//
// usage
// - input channel in_valid/in_ready/in_data carries place, row and read items;
//   output channel out_valid/out_ready/out_data returns one result per item
// - every input transfer gives exactly one output transfer, in order
// - the front takes an item whenever the four-entry queue has room
// - the back runs one command at a time on a single-port 4096 x 64 atlas
//   memory: a row write is a read-modify-write of two adjacent words, through
//   states RDA, RDB, WRA, WRB and then OUT; a read passes RDR and then OUT;
//   place and reject results go straight to OUT; the memory port sets the sustained rate
// - after reset the back clears the atlas, one word a cycle, all 4096 words;
//   in_ready stays low until that pass ends
// - when the receiver stalls, the result waits in the output register and
//   the front keeps filling the queue until it is full
module glyph_atlas_shelf_packer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gasp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output gasp_pkg::out_item_t out_data
);

	gasp_pkg::cmd_t cmd, head;
	logic           full, empty, pop, init_done;

	// front stalls on a full queue or while the atlas is being cleared
	assign in_ready = !full && init_done;

	gasp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cmd      (cmd)
	);

	gasp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && in_ready),
		.push_data (cmd),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	gasp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.init_done (init_done),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> rtl/core/gasp_front.sv
`timescale 1ns / 1ps
// gasp_front: accepts items, keeps the shelf cursor state, decodes hex rows
// and emits commands for the back part; uses gasp_pkg
module gasp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  gasp_pkg::in_item_t in_data,
	output gasp_pkg::cmd_t    cmd
);

	logic [9:0] cursor_col_q, cursor_row_q, shelf_bottom_q;
	logic [9:0] origin_col_q, write_row_q, rows_left_q;
	logic [5:0] pending_width_q;
	logic       glyph_fitted_q;

	logic [9:0] cursor_col_d, cursor_row_d, shelf_bottom_d;
	logic [9:0] origin_col_d, write_row_d, rows_left_d;
	logic [5:0] pending_width_d;
	logic       glyph_fitted_d;

	logic [10:0] col_sum, col_fit_sum, row_sum;
	logic [9:0]  col_eff, row_eff;
	logic        wide, wrap, fit;
	logic [3:0]  len;
	logic [gasp_pkg::PAT_W-1:0] pattern, mask;

	// returns {valid, nibble} of one uppercase hex character
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c[3:0] + 4'd9)};
		return r;
	endfunction

	assign len = (in_data.row_length > 4'd8) ? 4'd8 : in_data.row_length;

	// each byte takes two characters, an invalid one is skipped without shifting
	always_comb begin
		logic [4:0] hi, lo;
		for (int i = 0; i < gasp_pkg::PAT_W / 8; i++) begin
			hi = hex_nib(in_data.row_text[63 - 16 * i -: 8]);
			lo = hex_nib(in_data.row_text[55 - 16 * i -: 8]);
			if (4'(2 * i) >= len) hi[4] = 1'b0;
			if (4'(2 * i + 1) >= len) lo[4] = 1'b0;
			case ({hi[4], lo[4]})
				2'b11:   pattern[gasp_pkg::PAT_W - 1 - 8 * i -: 8] = {hi[3:0], lo[3:0]};
				2'b10:   pattern[gasp_pkg::PAT_W - 1 - 8 * i -: 8] = {4'h0, hi[3:0]};
				2'b01:   pattern[gasp_pkg::PAT_W - 1 - 8 * i -: 8] = {4'h0, lo[3:0]};
				default: pattern[gasp_pkg::PAT_W - 1 - 8 * i -: 8] = 8'h00;
			endcase
		end
	end

	assign mask = ~({gasp_pkg::PAT_W{1'b1}} >> pending_width_q);

	assign wide        = in_data.glyph_width > 6'(gasp_pkg::MAX_GLYPH_WIDTH);
	assign col_sum     = {1'b0, cursor_col_q} + 11'(in_data.glyph_width);
	assign wrap        = col_sum > 11'(gasp_pkg::ATLAS_WIDTH);
	assign col_eff     = wrap ? 10'd0 : cursor_col_q;
	assign row_eff     = wrap ? shelf_bottom_q : cursor_row_q;
	assign col_fit_sum = {1'b0, col_eff} + 11'(in_data.glyph_width);
	assign row_sum     = {1'b0, row_eff} + {1'b0, in_data.glyph_height};
	assign fit = (col_fit_sum <= 11'(gasp_pkg::ATLAS_WIDTH))
		&& (row_sum <= 11'(gasp_pkg::ATLAS_HEIGHT));

	always_comb begin
		cursor_col_d    = cursor_col_q;
		cursor_row_d    = cursor_row_q;
		shelf_bottom_d  = shelf_bottom_q;
		origin_col_d    = origin_col_q;
		write_row_d     = write_row_q;
		rows_left_d     = rows_left_q;
		pending_width_d = pending_width_q;
		glyph_fitted_d  = glyph_fitted_q;
		cmd             = '0;
		cmd.op          = gasp_pkg::OP_RESULT;
		case (gasp_pkg::kind_t'(in_data.kind))
			gasp_pkg::KIND_PLACE: begin
				cmd.res.place_x = 10'(gasp_pkg::ATLAS_WIDTH);
				cmd.res.place_y = 10'(gasp_pkg::ATLAS_HEIGHT);
				rows_left_d     = 10'd0;
				glyph_fitted_d  = 1'b0;
				if (wide) begin
					cmd.res.rejected = 1'b1;
				end else begin
					cursor_row_d    = row_eff;
					cursor_col_d    = fit ? col_fit_sum[9:0] : col_eff;
					if (fit && row_sum > {1'b0, shelf_bottom_q})
						shelf_bottom_d = row_sum[9:0];
					if (fit) begin
						cmd.res.place_x = col_eff;
						cmd.res.place_y = row_eff;
						cmd.res.placed  = 1'b1;
					end
					glyph_fitted_d  = fit;
					pending_width_d = in_data.glyph_width;
					rows_left_d     = in_data.glyph_height;
					origin_col_d    = fit ? col_eff : 10'd0;
					write_row_d     = fit ? row_eff : 10'd0;
				end
			end
			gasp_pkg::KIND_ROW: begin
				if (rows_left_q == 10'd0) begin
					cmd.res.rejected = 1'b1;
				end else begin
					rows_left_d = rows_left_q - 10'd1;
					if (glyph_fitted_q) begin
						cmd.op        = gasp_pkg::OP_WRITE;
						cmd.word_addr = {write_row_q[gasp_pkg::ROW_AW-1:0],
							origin_col_q[gasp_pkg::COL_AW-1:gasp_pkg::OFF_W]};
						cmd.bit_off   = origin_col_q[gasp_pkg::OFF_W-1:0];
						cmd.pattern   = pattern & mask;
						cmd.mask      = mask;
						write_row_d   = write_row_q + 10'd1;
					end
				end
			end
			gasp_pkg::KIND_READ: begin
				cmd.op        = gasp_pkg::OP_READ;
				cmd.word_addr = in_data.read_address[14:3];
				cmd.byte_sel  = in_data.read_address[2:0];
			end
			default: begin
				cmd.res.rejected = 1'b1;
			end
		endcase
		cmd.res.used_height = shelf_bottom_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q    <= '0;
			cursor_row_q    <= '0;
			shelf_bottom_q  <= '0;
			origin_col_q    <= '0;
			write_row_q     <= '0;
			rows_left_q     <= '0;
			pending_width_q <= '0;
			glyph_fitted_q  <= 1'b0;
		end else if (in_valid && in_ready) begin
			cursor_col_q    <= cursor_col_d;
			cursor_row_q    <= cursor_row_d;
			shelf_bottom_q  <= shelf_bottom_d;
			origin_col_q    <= origin_col_d;
			write_row_q     <= write_row_d;
			rows_left_q     <= rows_left_d;
			pending_width_q <= pending_width_d;
			glyph_fitted_q  <= glyph_fitted_d;
		end
	end

endmodule

>>> rtl/core/gasp_fifo.sv
`timescale 1ns / 1ps
// gasp_fifo: short command queue between front and back parts
// uses gasp_pkg
module gasp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gasp_pkg::cmd_t push_data,
	input  logic           pop,
	output gasp_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);

	gasp_pkg::cmd_t entries_q [gasp_pkg::FIFO_DEPTH];
	logic [gasp_pkg::FIFO_AW:0] wr_ptr_q, rd_ptr_q;

	assign empty = wr_ptr_q == rd_ptr_q;
	assign full  = (wr_ptr_q[gasp_pkg::FIFO_AW] != rd_ptr_q[gasp_pkg::FIFO_AW])
		&& (wr_ptr_q[gasp_pkg::FIFO_AW-1:0] == rd_ptr_q[gasp_pkg::FIFO_AW-1:0]);
	assign head  = entries_q[rd_ptr_q[gasp_pkg::FIFO_AW-1:0]];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q[gasp_pkg::FIFO_AW-1:0]] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

endmodule

>>> rtl/core/gasp_back.sv
`timescale 1ns / 1ps
// gasp_back: atlas memory, clearing pass, row read-modify-write, byte reads
// and the result register; uses gasp_pkg
module gasp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  gasp_pkg::cmd_t      head,
	input  logic                empty,
	output logic                pop,
	output logic                init_done,
	output logic                out_valid,
	input  logic                out_ready,
	output gasp_pkg::out_item_t out_data
);

	logic [gasp_pkg::WORD_BITS-1:0] mem [gasp_pkg::ATLAS_WORDS];
	logic [gasp_pkg::WORD_BITS-1:0] mem_rd_q, word_a_q, word_b_q, wdata;
	logic [gasp_pkg::WORD_AW-1:0]   clr_q, addr;
	logic                           we, re, load;
	gasp_pkg::bk_state_t            state_q, state_d;
	gasp_pkg::out_item_t            out_q, out_d;
	logic                           out_valid_q;
	logic [2*gasp_pkg::WORD_BITS-1:0] pat_win, mask_win;
	logic [7:0]                     rd_byte;

	assign pat_win  = {head.pattern, {(2*gasp_pkg::WORD_BITS-gasp_pkg::PAT_W){1'b0}}}
		>> head.bit_off;
	assign mask_win = {head.mask, {(2*gasp_pkg::WORD_BITS-gasp_pkg::PAT_W){1'b0}}}
		>> head.bit_off;
	assign rd_byte  = mem_rd_q[gasp_pkg::WORD_BITS - 1 - 8 * head.byte_sel -: 8];
	assign load     = !out_valid_q || out_ready;

	// result word, with the atlas byte merged in for a read
	always_comb begin
		out_d = head.res;
		if (head.op == gasp_pkg::OP_READ) out_d.read_data = rd_byte;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gasp_pkg::BK_CLEAR: if (clr_q == gasp_pkg::WORD_AW'(gasp_pkg::ATLAS_WORDS - 1))
				state_d = gasp_pkg::BK_IDLE;
			gasp_pkg::BK_IDLE: begin
				if (!empty) begin
					case (head.op)
						gasp_pkg::OP_WRITE: state_d = gasp_pkg::BK_RDA;
						gasp_pkg::OP_READ:  state_d = gasp_pkg::BK_RDR;
						default:            state_d = gasp_pkg::BK_OUT;
					endcase
				end
			end
			gasp_pkg::BK_RDA: state_d = gasp_pkg::BK_RDB;
			gasp_pkg::BK_RDB: state_d = gasp_pkg::BK_WRA;
			gasp_pkg::BK_WRA: state_d = gasp_pkg::BK_WRB;
			gasp_pkg::BK_WRB: state_d = gasp_pkg::BK_OUT;
			gasp_pkg::BK_RDR: state_d = gasp_pkg::BK_OUT;
			gasp_pkg::BK_OUT: if (load) state_d = gasp_pkg::BK_IDLE;
			default: state_d = gasp_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		addr  = head.word_addr;
		wdata = '0;
		pop   = 1'b0;
		case (state_q)
			gasp_pkg::BK_CLEAR: begin
				we   = 1'b1;
				addr = clr_q;
			end
			gasp_pkg::BK_RDA: re = 1'b1;
			gasp_pkg::BK_RDB: begin
				re   = 1'b1;
				addr = head.word_addr + 1'b1;
			end
			gasp_pkg::BK_WRA: begin
				we    = 1'b1;
				wdata = (word_a_q & ~mask_win[2*gasp_pkg::WORD_BITS-1:gasp_pkg::WORD_BITS])
					| pat_win[2*gasp_pkg::WORD_BITS-1:gasp_pkg::WORD_BITS];
			end
			gasp_pkg::BK_WRB: begin
				// second word is unchanged when the glyph stays in the first
				we    = 1'b1;
				addr  = head.word_addr + 1'b1;
				wdata = (word_b_q & ~mask_win[gasp_pkg::WORD_BITS-1:0])
					| pat_win[gasp_pkg::WORD_BITS-1:0];
			end
			gasp_pkg::BK_RDR: re = 1'b1;
			gasp_pkg::BK_OUT: pop = load;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		if (re) mem_rd_q <= mem[addr];
		if (state_q == gasp_pkg::BK_RDB) word_a_q <= mem_rd_q;
		if (state_q == gasp_pkg::BK_WRA) word_b_q <= mem_rd_q;
		if (pop) out_q <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gasp_pkg::BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == gasp_pkg::BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (pop) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign init_done = state_q != gasp_pkg::BK_CLEAR;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gasp_pkg::BK_CLEAR |-> !pop)
		else $error("queue popped during clearing pass");
	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == gasp_pkg::BK_CLEAR || state_q == gasp_pkg::BK_WRA
			|| state_q == gasp_pkg::BK_WRB))
		else $error("atlas write outside clear or row write");
	a_wra_wrb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gasp_pkg::BK_WRA |=> state_q == gasp_pkg::BK_WRB)
		else $error("row write lost its second word");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for glyph_atlas_shelf_packer
// drives place, row, read and bad-kind transfers, predicts every result, compares in order
// uses gasp_pkg and the rtl under rtl/core
module testbench;
	import gasp_pkg::*;

	localparam int STRIDE = (ATLAS_WIDTH + 7) / 8;
	localparam int NBYTES = STRIDE * ATLAS_HEIGHT;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	glyph_atlas_shelf_packer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// packer state mirror
	logic [9:0] cur_col, cur_row, shelf_bot, org_col, wr_row, rows_pend;
	logic [5:0] pend_w;
	logic       fitted;
	logic [7:0] atlas_mem [NBYTES];

	in_item_t  pending_items [$];
	out_item_t expected_results [$];
	int        error_count;
	int        results_seen;
	int        places_ok, places_failed, reads_done;
	bit        stim_done;
	bit        no_idle;
	bit        hold_sender;
	bit        in_fire;
	int        send_gap, recv_gap;

	// one 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [3:0] hex_value(input logic [7:0] c, output bit ok);
		ok = 1'b1;
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		ok = 1'b0;
		return 4'd0;
	endfunction

	// write one hex row of the pending glyph into the atlas mirror
	task automatic paint_row(input logic [63:0] text, input logic [3:0] len_in);
		int nb, pos, dx, lim, len, col, idx;
		logic [7:0] b;
		logic [7:0] c;
		logic [3:0] d;
		bit ok;
		nb = (pend_w + 7) / 8;
		pos = 0;
		dx = 0;
		lim = 8;
		len = (len_in > 8) ? 8 : len_in;
		for (int i = 0; i < nb; i++) begin
			b = 8'd0;
			for (int k = 0; k < 2; k++) begin
				if (pos < len) begin
					c = text[63 - 8*pos -: 8];
					d = hex_value(c, ok);
					if (ok) b = {b[3:0], d};
					pos++;
				end
			end
			if (lim > pend_w) lim = pend_w;
			for (int k = 0; dx < lim; dx++, k++) begin
				col = org_col + dx;
				if (wr_row < ATLAS_HEIGHT && col < ATLAS_WIDTH) begin
					idx = wr_row * STRIDE + col / 8;
					atlas_mem[idx][7 - col % 8] = b[7 - k % 8];
				end
			end
			lim += 8;
		end
	endtask

	// advance the mirror by one accepted transfer and queue its result
	task automatic predict_packer(input in_item_t it);
		out_item_t r;
		int w, h;
		r = '0;
		case (kind_t'(it.kind))
			KIND_PLACE: begin
				w = it.glyph_width;
				h = it.glyph_height;
				r.place_x = ATLAS_WIDTH;
				r.place_y = ATLAS_HEIGHT;
				rows_pend = 0;
				fitted = 1'b0;
				if (w > MAX_GLYPH_WIDTH) begin
					r.rejected = 1'b1;
				end else begin
					// new shelf when the glyph runs past the right edge
					if (cur_col + w > ATLAS_WIDTH) begin
						cur_col = 0;
						cur_row = shelf_bot;
					end
					if (cur_col + w <= ATLAS_WIDTH && cur_row + h <= ATLAS_HEIGHT) begin
						r.place_x = cur_col;
						r.place_y = cur_row;
						r.placed = 1'b1;
						cur_col = cur_col + w;
						if (cur_row + h > shelf_bot) shelf_bot = cur_row + h;
					end
					fitted = r.placed;
					pend_w = w;
					rows_pend = h;
					org_col = r.placed ? r.place_x : 10'd0;
					wr_row = r.placed ? r.place_y : 10'd0;
					if (r.placed) places_ok++; else places_failed++;
				end
			end
			KIND_ROW: begin
				if (rows_pend == 0) begin
					r.rejected = 1'b1;
				end else begin
					rows_pend--;
					if (fitted) begin
						paint_row(it.row_text, it.row_length);
						wr_row++;
					end
				end
			end
			KIND_READ: begin
				reads_done++;
				r.read_data = (it.read_address < NBYTES) ? atlas_mem[it.read_address] : 8'd0;
			end
			default: r.rejected = 1'b1;
		endcase
		r.used_height = shelf_bot;
		expected_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got,
			want);
		error_count++;
	endtask

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire) begin
				predict_packer(in_data);
			end
			if (!(in_valid && !in_fire)) begin
				if (send_gap > 0) send_gap--;
				if (pending_items.size() > 0 && send_gap == 0 && !hold_sender) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
					if (!no_idle && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(1, 19);
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 11) == 0) begin
				recv_gap = $urandom_range(1, 19);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: input transfers and results sampled on the rising edge
	always @(posedge clk) begin
		out_item_t e;
		in_fire = arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result transfer", 1, 0);
			end else begin
				e = expected_results.pop_front();
				if (out_data.place_x != e.place_x)
					report_mismatch("place_x", out_data.place_x, e.place_x);
				if (out_data.place_y != e.place_y)
					report_mismatch("place_y", out_data.place_y, e.place_y);
				if (out_data.placed != e.placed)
					report_mismatch("placed", out_data.placed, e.placed);
				if (out_data.rejected != e.rejected)
					report_mismatch("rejected", out_data.rejected, e.rejected);
				if (out_data.read_data != e.read_data)
					report_mismatch("read_data", out_data.read_data, e.read_data);
				if (out_data.used_height != e.used_height)
					report_mismatch("used_height", out_data.used_height, e.used_height);
			end
			results_seen++;
		end
	end

	function automatic logic [7:0] hex_char(input int v);
		return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
	endfunction

	function automatic in_item_t item_place(input int w, input int h);
		in_item_t it;
		it = '0;
		it.kind = KIND_PLACE;
		it.glyph_width = w;
		it.glyph_height = h;
		it.row_text = {$urandom, $urandom};
		it.read_address = $urandom;
		return it;
	endfunction

	// mostly well-formed hex with occasional junk characters
	function automatic in_item_t item_row(input bit junk);
		in_item_t it;
		it = '0;
		it.kind = KIND_ROW;
		it.row_length = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : 8;
		for (int i = 0; i < 8; i++)
			it.row_text[63 - 8*i -: 8] = junk && $urandom_range(0, 3) == 0 ? 8'($urandom)
				: hex_char($urandom_range(0, 15));
		it.glyph_width = $urandom;
		it.glyph_height = $urandom;
		return it;
	endfunction

	function automatic in_item_t item_read(input int a);
		in_item_t it;
		it = '0;
		it.kind = KIND_READ;
		it.read_address = a;
		it.row_text = {$urandom, $urandom};
		return it;
	endfunction

	task automatic wait_drained;
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	// read back up to four rows of five bytes each, starting at the byte under (x, y)
	task automatic queue_readback(input int x, input int y, input int h);
		for (int r = 0; r < h && r < 4; r++)
			for (int b = 0; b < 5; b++)
				pending_items.push_back(item_read((y + r) * STRIDE + (x / 8) + b));
	endtask

	initial begin
		in_item_t it;
		int w, h, n, cx;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		error_count = 0;
		results_seen = 0;
		places_ok = 0;
		places_failed = 0;
		reads_done = 0;
		stim_done = 1'b0;
		no_idle = 1'b0;
		hold_sender = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		cur_col = 0; cur_row = 0; shelf_bot = 0; org_col = 0; wr_row = 0;
		rows_pend = 0; pend_w = 0; fitted = 1'b0;
		foreach (atlas_mem[i]) atlas_mem[i] = 8'd0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: rows with none pending, unknown kind, wide and odd glyphs
		pending_items.push_back(item_row(0));
		it = item_read(0); it.kind = KIND_BAD; pending_items.push_back(it);
		pending_items.push_back(item_place(33, 4));
		pending_items.push_back(item_place(63, 1023));
		pending_items.push_back(item_row(0));
		pending_items.push_back(item_place(0, 2));
		pending_items.push_back(item_row(0));
		pending_items.push_back(item_row(0));
		pending_items.push_back(item_place(5, 0));
		pending_items.push_back(item_place(32, 2));
		it = item_row(0); it.row_text = "F0g0A5zz"; pending_items.push_back(it);
		it = item_row(0); it.row_text = "FFFFFFFF"; it.row_length = 15;
		pending_items.push_back(it);
		pending_items.push_back(item_read(0));
		pending_items.push_back(item_read(4));
		pending_items.push_back(item_read(5));
		pending_items.push_back(item_read(NBYTES - 1));
		pending_items.push_back(item_read(NBYTES));
		pending_items.push_back(item_read(32767));
		pending_items.push_back(item_place(32, 1023));
		pending_items.push_back(item_row(0));
		wait_drained();

		// random glyph sequences: place, its rows, then readback
		n = 0;
		while (n < 1100) begin
			if (n > 950) no_idle = 1'b1;
			w = $urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(1, 32);
			h = $urandom_range(0, 15) == 0 ? $urandom_range(0, 600) : $urandom_range(0, 12);
			pending_items.push_back(item_place(w, h));
			cx = cur_col;
			n++;
			for (int r = 0; r < h && r < 12; r++) begin
				pending_items.push_back(item_row($urandom_range(0, 4) == 0));
				n++;
			end
			if ($urandom_range(0, 5) == 0) begin
				pending_items.push_back(item_row(0));
				n++;
			end
			for (int k = 0; k < 3; k++) begin
				pending_items.push_back(item_read($urandom_range(0, 32767) %
					($urandom_range(0, 1) ? 32768 : 2048)));
				n++;
			end
			if ($urandom_range(0, 60) == 0) begin
				it = item_read($urandom); it.kind = KIND_BAD;
				pending_items.push_back(it);
				n++;
			end
			// wait until all results are back, then queue reads of the glyph area with the sender held
			if ($urandom_range(0, 40) == 0) begin
				wait_drained();
				hold_sender = 1'b1;
				queue_readback(cx, shelf_bot > 12 ? shelf_bot - 12 : 0, 4);
				n += 20;
				@(negedge clk);
				hold_sender = 1'b0;
			end
			while (pending_items.size() > 40) @(posedge clk);
		end
		wait_drained();
		for (int a = 0; a < 64; a++) pending_items.push_back(item_read(a));
		wait_drained();
		repeat (20) @(posedge clk);
		$display("covered %0d results: %0d glyphs placed, %0d failed, %0d reads",
			results_seen, places_ok, places_failed, reads_done);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
